/* hdl/tmb_pkg.sv */
// Package for the timeout bank: channel count, operation and state codes,
// table entry and op unit structs. No dependencies.
`default_nettype none

package tmb_pkg;

    localparam int unsigned CHANNELS = 16;
    localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned TICK_W   = 32;

    typedef enum logic [2:0] {
        K_START         = 3'd0,
        K_TEST          = 3'd1,
        K_STOP          = 3'd2,
        K_CHECK_RESTART = 3'd3,
        K_READ_STATE    = 3'd4,
        K_READ_ELAPSED  = 3'd5,
        K_SWEEP         = 3'd6,
        K_RESERVED      = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_NOT_STARTED = 2'd0,
        ST_STARTED     = 2'd1,
        ST_RUNNING     = 2'd2,
        ST_EXPIRED     = 2'd3
    } t_chan_st;

    // one channel's table word
    typedef struct packed {
        logic [TICK_W-1:0] tlen;
        logic [TICK_W-1:0] stamp;
        t_chan_st          st;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_kind             kind;
        logic              chan_ok;
        logic [TICK_W-1:0] tmo;
        logic [TICK_W-1:0] now;
    } t_op_req;

    typedef struct packed {
        logic              we;
        t_entry            entry;
        logic              le_we;
        logic [TICK_W-1:0] le_new;
        logic              flag;
        t_chan_st          status;
        logic [TICK_W-1:0] elapsed;
    } t_op_res;

endpackage

`default_nettype wire

/* hdl/tmb_in_if.sv */
// Input channel of the timeout bank: valid/ready plus one operation beat.
// Depends on nothing.
`default_nettype none

interface tmb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [31:0] timeout_ms;
    logic [31:0] now_ms;

    modport source (output valid, kind, channel, timeout_ms, now_ms, input ready);
    modport sink   (input valid, kind, channel, timeout_ms, now_ms, output ready);
endinterface

`default_nettype wire

/* hdl/tmb_out_if.sv */
// Result channel of the timeout bank: valid/ready plus one result beat.
// Depends on nothing.
`default_nettype none

interface tmb_out_if;
    logic        valid;
    logic        ready;
    logic        expired_flag;
    logic [1:0]  status;
    logic [31:0] elapsed_ms;

    modport source (output valid, expired_flag, status, elapsed_ms, input ready);
    modport sink   (input valid, expired_flag, status, elapsed_ms, output ready);
endinterface

`default_nettype wire

/* hdl/tmb_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data,
// read-before-write on an address collision. No dependencies.
`default_nettype none

module tmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/tmb_op_unit.sv */
// Operation unit: applies one operation to a channel entry and the shared
// last-elapsed value. Pure logic. Depends on tmb_pkg.
`default_nettype none

module tmb_op_unit
    import tmb_pkg::*;
(
    input  wire t_op_req           i_req,
    input  wire t_entry            i_entry,
    input  wire logic [TICK_W-1:0] i_last,
    output t_op_res                o_res
);

    logic              tst_active;
    logic [TICK_W-1:0] diff;
    t_chan_st          tst_st;

    always_comb begin
        tst_active = (i_entry.tlen != '0) && (i_entry.st != ST_NOT_STARTED);
        // elapsed clamps to zero when the tick is behind the stamp
        diff       = (i_req.now >= i_entry.stamp) ? (i_req.now - i_entry.stamp) : '0;
        tst_st     = (i_entry.tlen <= diff) ? ST_EXPIRED : ST_RUNNING;
    end

    always_comb begin
        o_res         = '0;
        o_res.entry   = i_entry;
        o_res.status  = ST_NOT_STARTED;

        unique case (i_req.kind) inside
            K_START: begin
                if (i_req.chan_ok) begin
                    o_res.we          = 1'b1;
                    o_res.entry.tlen  = i_req.tmo;
                    o_res.entry.stamp = i_req.now;
                    o_res.entry.st    = ST_RUNNING;
                end
            end
            K_TEST, K_SWEEP: begin
                if (i_req.chan_ok && tst_active) begin
                    o_res.we       = 1'b1;
                    o_res.entry.st = tst_st;
                    o_res.le_we    = 1'b1;
                    o_res.le_new   = diff;
                end
            end
            K_CHECK_RESTART: begin
                if (i_req.chan_ok && tst_active) begin
                    o_res.we     = 1'b1;
                    o_res.le_we  = 1'b1;
                    o_res.le_new = diff;
                    if (tst_st == ST_EXPIRED) begin
                        o_res.entry.stamp = i_req.now;
                        o_res.entry.st    = ST_RUNNING;
                        o_res.flag        = 1'b1;
                    end else begin
                        o_res.entry.st = tst_st;
                    end
                end
            end
            K_STOP: begin
                if (i_req.chan_ok) begin
                    o_res.we         = 1'b1;
                    o_res.entry.tlen = '0;
                    o_res.entry.st   = ST_NOT_STARTED;
                end
            end
            K_READ_ELAPSED: begin
                // cleared even when the channel is out of range
                o_res.le_we  = 1'b1;
                o_res.le_new = '0;
                if (i_req.chan_ok && (i_entry.st != ST_NOT_STARTED)) begin
                    o_res.elapsed = i_last;
                end
            end
            default: begin
            end
        endcase

        if (i_req.chan_ok) begin
            o_res.status = o_res.entry.st;
        end
    end

endmodule

`default_nettype wire

/* hdl/multi_channel_timeout_bank.sv */
// Timeout bank top level: issue stage, channel table RAM, op unit and
// result register. Depends on tmb_pkg, tmb_in_if, tmb_out_if, tmb_ram,
// tmb_op_unit.
//
// Usage: i_item carries one operation beat (kind, channel, timeout, current
// tick); o_result returns exactly one beat per operation, in order.
// Flow: an accepted beat is registered into the execute stage while its
// table word is read, then executed once the result register is free.
// Throughput: one operation per cycle while o_result is not held off, bounded
// by the single read and single write port of the channel table; a read of
// a channel issued with a write to it is taken from a bypass register.
// Reset: all channels read as not started, the sweep pointer and the shared
// last-elapsed value are zero. Per-entry valid flops mask stale RAM words,
// so the block accepts beats right after reset with no clearing pass.
// Stall: when o_result is held off, the result register keeps its beat and
// the execute stage keeps one more; i_item.ready drops once both are full.
`default_nettype none

module multi_channel_timeout_bank
    import tmb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tmb_in_if.sink    i_item,
    tmb_out_if.source o_result
);

    // issue side
    t_kind             s0_kind;
    logic [CH_W-1:0]   s0_addr;
    logic              s0_ok;
    logic              accept;

    // execute stage
    logic              r_s1_valid;
    t_kind             r_s1_kind;
    logic              r_s1_ok;
    logic [CH_W-1:0]   r_s1_addr;
    logic [TICK_W-1:0] r_s1_tmo;
    logic [TICK_W-1:0] r_s1_now;
    logic              s1_fire;
    logic              out_free;

    logic [CH_W-1:0]   r_sweep;
    logic [CH_W-1:0]   n_sweep;
    logic [TICK_W-1:0] r_last;
    logic [CHANNELS-1:0] r_vld;
    logic              r_fwd;
    t_entry            r_fwd_entry;
    logic [ENTRY_W-1:0] ram_q;
    t_entry            s1_entry;
    t_op_req           op_req;
    t_op_res           op_res;

    // result register
    logic              r_out_valid;
    logic              r_out_flag;
    t_chan_st          r_out_status;
    logic [TICK_W-1:0] r_out_elapsed;

    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_fire      = r_s1_valid && out_free;
    assign i_item.ready = !r_s1_valid || out_free;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        s0_kind = t_kind'(i_item.kind);
        s0_ok   = (s0_kind == K_SWEEP) || (32'(i_item.channel) < CHANNELS);
        s0_addr = (s0_kind == K_SWEEP) ? r_sweep : CH_W'(i_item.channel);
        n_sweep = (r_sweep == CH_W'(CHANNELS - 1)) ? '0 : r_sweep + 1'b1;
    end

    tmb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (s1_fire && op_res.we),
        .i_waddr (r_s1_addr),
        .i_wdata (op_res.entry),
        .i_re    (accept),
        .i_raddr (s0_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (r_fwd) begin
            s1_entry = r_fwd_entry;
        end else if (r_vld[r_s1_addr]) begin
            s1_entry = t_entry'(ram_q);
        end else begin
            s1_entry = '0;
        end
        op_req.kind    = r_s1_kind;
        op_req.chan_ok = r_s1_ok;
        op_req.tmo     = r_s1_tmo;
        op_req.now     = r_s1_now;
    end

    tmb_op_unit u_op (
        .i_req   (op_req),
        .i_entry (s1_entry),
        .i_last  (r_last),
        .o_res   (op_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sweep     <= '0;
            r_last      <= '0;
            r_vld       <= '0;
            r_fwd       <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (accept && (s0_kind == K_SWEEP)) begin
                r_sweep <= n_sweep;
            end

            if (s1_fire && op_res.le_we) begin
                r_last <= op_res.le_new;
            end

            if (s1_fire && op_res.we) begin
                r_vld[r_s1_addr] <= 1'b1;
            end

            // same-channel back-to-back: RAM returns the old word, use bypass
            if (accept) begin
                r_fwd <= s1_fire && op_res.we && (r_s1_addr == s0_addr);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind   <= s0_kind;
            r_s1_ok     <= s0_ok;
            r_s1_addr   <= s0_addr;
            r_s1_tmo    <= i_item.timeout_ms;
            r_s1_now    <= i_item.now_ms;
            r_fwd_entry <= op_res.entry;
        end
        if (s1_fire) begin
            r_out_flag    <= op_res.flag;
            r_out_status  <= op_res.status;
            r_out_elapsed <= op_res.elapsed;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.expired_flag = r_out_flag;
    assign o_result.status       = r_out_status;
    assign o_result.elapsed_ms   = r_out_elapsed;

    // a restart always leaves the channel running
    a_flag_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.expired_flag) |-> (o_result.status == ST_RUNNING))
        else $error("expired flag with channel not running");

    // input back-pressure only when both stages hold a beat
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // a same-channel write under a read must arm the bypass
    a_fwd_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s1_fire && op_res.we && (r_s1_addr == s0_addr)) |=> r_fwd)
        else $error("bypass not armed on same-channel collision");

    // every accepted beat reaches the execute stage
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted beat lost before execute");

endmodule

`default_nettype wire
